### src/vara_pkg.sv
// ----------------------------------------------------------------------------
// vara_pkg
// Shared types, constants and rounding helper for the vector alignment
// rotation matrix pipeline.
// ----------------------------------------------------------------------------
package vara_pkg;

  localparam int VEC_WIDTH = 16;
  localparam int CFG_WIDTH = 31;

  localparam logic [CFG_WIDTH-1:0] LIMIT_RESET = 31'd1074;

  // pipeline depths
  localparam int SHIFT_STEPS = 5;
  localparam int SQRT_LAT    = 31;
  localparam int DIV_LAT     = 31;
  localparam int UNIT_LAT    = 4 + SHIFT_STEPS + SQRT_LAT + DIV_LAT;
  localparam int CROSS_LAT   = 2;
  localparam int MATRIX_LAT  = 5;
  localparam int PIPE_LAT    = 2 * UNIT_LAT + CROSS_LAT + MATRIX_LAT;

  localparam int FRAC_Q30  = 30;
  localparam int OUT_SHIFT = 46;

  typedef logic signed [31:0] q30_t;
  typedef logic signed [15:0] q14_t;
  typedef logic signed [66:0] wide_t;

  localparam q14_t ONE_Q14 = 16'sd16384;
  localparam q14_t MAX_Q14 = 16'sd32767;
  localparam q14_t MIN_Q14 = -16'sd32768;

  typedef enum logic [1:0] {
    ST_ROTATION = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_ZERO     = 2'd2
  } status_t;

  // arithmetic shift right with rounding half away from zero
  function automatic wide_t round_shift(input wide_t val, input int unsigned sh);
    wide_t mag;
    wide_t rnd;
    mag = val[66] ? -val : val;
    rnd = (mag + (wide_t'(1) << (sh - 1))) >> sh;
    return val[66] ? -rnd : rnd;
  endfunction

endpackage

### src/vara_sqrt.sv
// ----------------------------------------------------------------------------
// vara_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vara_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [61:0] radicand,
  output logic [30:0] root
);

  logic [32:0] rem_q  [vara_pkg::SQRT_LAT];
  logic [30:0] root_q [vara_pkg::SQRT_LAT];
  logic [61:0] bits_q [vara_pkg::SQRT_LAT];

  for (genvar g = 0; g < vara_pkg::SQRT_LAT; g++) begin : g_stage
    logic [32:0] rem_in;
    logic [30:0] root_in;
    logic [61:0] bits_in;
    logic [34:0] cur;
    logic [34:0] trial;
    logic        fits;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign bits_in = radicand;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign bits_in = bits_q[g-1];
    end

    assign cur   = {rem_in, bits_in[61:60]};
    assign trial = {2'b00, root_in, 2'b01};
    assign fits  = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g]  <= fits ? 33'(cur - trial) : cur[32:0];
        root_q[g] <= {root_in[29:0], fits};
        bits_q[g] <= {bits_in[59:0], 2'b00};
      end
    end
  end

  assign root = root_q[vara_pkg::SQRT_LAT-1];

endmodule

### src/vara_div.sv
// ----------------------------------------------------------------------------
// vara_div
// Pipelined restoring divider, one quotient bit per stage.
// Dividend must be below divisor * 2^31.
// ----------------------------------------------------------------------------
module vara_div (
  input  logic        clk,
  input  logic        en,
  input  logic [61:0] dividend,
  input  logic [30:0] divisor,
  output logic [30:0] quotient
);

  logic [30:0] rem_q [vara_pkg::DIV_LAT];
  logic [30:0] low_q [vara_pkg::DIV_LAT];
  logic [30:0] den_q [vara_pkg::DIV_LAT];
  logic [30:0] quo_q [vara_pkg::DIV_LAT];

  for (genvar g = 0; g < vara_pkg::DIV_LAT; g++) begin : g_stage
    logic [30:0] rem_in;
    logic [30:0] low_in;
    logic [30:0] den_in;
    logic [30:0] quo_in;
    logic [31:0] cur;
    logic        fits;

    if (g == 0) begin : g_first
      assign rem_in = dividend[61:31];
      assign low_in = dividend[30:0];
      assign den_in = divisor;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign low_in = low_q[g-1];
      assign den_in = den_q[g-1];
      assign quo_in = quo_q[g-1];
    end

    assign cur  = {rem_in, low_in[30]};
    assign fits = (cur >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g] <= fits ? 31'(cur - {1'b0, den_in}) : cur[30:0];
        low_q[g] <= {low_in[29:0], 1'b0};
        den_q[g] <= den_in;
        quo_q[g] <= {quo_in[29:0], fits};
      end
    end
  end

  assign quotient = quo_q[vara_pkg::DIV_LAT-1];

endmodule

### src/vara_unit3.sv
// ----------------------------------------------------------------------------
// vara_unit3
// Scales a three-component vector to unit length in Q1.30: squared length,
// normalising shift, square root, three dividers. Also gives the plain
// length floor(sqrt(sum of squares)) and a zero-vector flag.
// ----------------------------------------------------------------------------
module vara_unit3 (
  input  logic           clk,
  input  logic           en,
  input  vara_pkg::q30_t comp [3],
  output vara_pkg::q30_t unit_vec [3],
  output logic [30:0]    length,
  output logic           zero
);

  typedef struct packed {
    logic [63:0]      n2;
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic [4:0]       k;
    logic             zero;
  } norm_t;

  typedef struct packed {
    logic [2:0][30:0] mag;
    logic [2:0]       neg;
    logic [4:0]       k;
    logic             zero;
  } root_sb_t;

  typedef struct packed {
    logic [2:0]  neg;
    logic [4:0]  k;
    logic [30:0] n;
    logic        zero;
  } quo_sb_t;

  logic [31:0] mag_c  [3];
  logic [31:0] mag1_q [3];
  logic [63:0] sq1_q  [3];
  logic [2:0]  neg1_q;
  norm_t       s2_q;
  norm_t       nrm_q  [vara_pkg::SHIFT_STEPS];
  root_sb_t    rsb_q  [vara_pkg::SQRT_LAT];
  logic [30:0] root;
  logic [61:0] num_q  [3];
  quo_sb_t     dsb_q;
  quo_sb_t     qsb_q  [vara_pkg::DIV_LAT];
  logic [30:0] quo    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = comp[i][31] ? 32'(-comp[i]) : 32'(comp[i]);
    end
  end

  // squares, then their sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1_q[i] <= mag_c[i];
        neg1_q[i] <= comp[i][31];
        sq1_q[i]  <= 64'(mag_c[i]) * 64'(mag_c[i]);
      end
      s2_q.n2   <= sq1_q[0] + sq1_q[1] + sq1_q[2];
      s2_q.neg  <= neg1_q;
      s2_q.k    <= '0;
      s2_q.zero <= (sq1_q[0] == '0) && (sq1_q[1] == '0) && (sq1_q[2] == '0);
      for (int i = 0; i < 3; i++) begin
        s2_q.mag[i] <= mag1_q[i];
      end
    end
  end

  // binary search for the doubling count, largest step first
  for (genvar g = 0; g < vara_pkg::SHIFT_STEPS; g++) begin : g_shift
    localparam int STEP = 16 >> g;
    norm_t cur_in;
    norm_t nrm_next;
    logic  room;

    if (g == 0) begin : g_first
      assign cur_in = s2_q;
    end else begin : g_next
      assign cur_in = nrm_q[g-1];
    end

    assign room = (cur_in.n2 < (64'd1 << (62 - 2 * STEP)));

    always_comb begin
      nrm_next = cur_in;
      if (room) begin
        nrm_next.n2 = cur_in.n2 << (2 * STEP);
        for (int i = 0; i < 3; i++) begin
          nrm_next.mag[i] = cur_in.mag[i] << STEP;
        end
        nrm_next.k = cur_in.k | 5'(STEP);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nrm_q[g] <= nrm_next;
      end
    end
  end

  vara_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (nrm_q[vara_pkg::SHIFT_STEPS-1].n2[61:0]),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rsb_q[0].mag[i] <= nrm_q[vara_pkg::SHIFT_STEPS-1].mag[i][30:0];
      end
      rsb_q[0].neg  <= nrm_q[vara_pkg::SHIFT_STEPS-1].neg;
      rsb_q[0].k    <= nrm_q[vara_pkg::SHIFT_STEPS-1].k;
      rsb_q[0].zero <= nrm_q[vara_pkg::SHIFT_STEPS-1].zero;
      for (int j = 1; j < vara_pkg::SQRT_LAT; j++) begin
        rsb_q[j] <= rsb_q[j-1];
      end
    end
  end

  // dividend = mag * 2^30 + n/2 for rounding
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= {1'b0, rsb_q[vara_pkg::SQRT_LAT-1].mag[i], 30'b0} + 62'(root >> 1);
      end
      dsb_q.neg  <= rsb_q[vara_pkg::SQRT_LAT-1].neg;
      dsb_q.k    <= rsb_q[vara_pkg::SQRT_LAT-1].k;
      dsb_q.zero <= rsb_q[vara_pkg::SQRT_LAT-1].zero;
      dsb_q.n    <= root;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    vara_div u_div (
      .clk      (clk),
      .en       (en),
      .dividend (num_q[i]),
      .divisor  (dsb_q.n),
      .quotient (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qsb_q[0] <= dsb_q;
      for (int j = 1; j < vara_pkg::DIV_LAT; j++) begin
        qsb_q[j] <= qsb_q[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        unit_vec[i] <= qsb_q[vara_pkg::DIV_LAT-1].neg[i] ? -vara_pkg::q30_t'({1'b0, quo[i]})
                                                         : vara_pkg::q30_t'({1'b0, quo[i]});
      end
      // floor(sqrt(x * 4^k)) >> k equals floor(sqrt(x))
      length <= qsb_q[vara_pkg::DIV_LAT-1].n >> qsb_q[vara_pkg::DIV_LAT-1].k;
      zero   <= qsb_q[vara_pkg::DIV_LAT-1].zero;
    end
  end

endmodule

### src/vara_cross.sv
// ----------------------------------------------------------------------------
// vara_cross
// Cross and dot product of two Q1.30 unit vectors, rounded back to Q1.30.
// ----------------------------------------------------------------------------
module vara_cross (
  input  logic           clk,
  input  logic           en,
  input  vara_pkg::q30_t a [3],
  input  vara_pkg::q30_t b [3],
  input  logic           degen_in,
  output vara_pkg::q30_t v [3],
  output vara_pkg::q30_t c,
  output logic           degen
);

  logic signed [63:0] prod_q [9];
  logic               degen_q;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_q[0] <= a[1] * b[2];
      prod_q[1] <= a[2] * b[1];
      prod_q[2] <= a[2] * b[0];
      prod_q[3] <= a[0] * b[2];
      prod_q[4] <= a[0] * b[1];
      prod_q[5] <= a[1] * b[0];
      prod_q[6] <= a[0] * b[0];
      prod_q[7] <= a[1] * b[1];
      prod_q[8] <= a[2] * b[2];
      degen_q   <= degen_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v[i] <= vara_pkg::q30_t'(vara_pkg::round_shift(
                  vara_pkg::wide_t'(prod_q[2*i]) - vara_pkg::wide_t'(prod_q[2*i+1]),
                  vara_pkg::FRAC_Q30));
      end
      c <= vara_pkg::q30_t'(vara_pkg::round_shift(
             vara_pkg::wide_t'(prod_q[6]) + vara_pkg::wide_t'(prod_q[7])
             + vara_pkg::wide_t'(prod_q[8]), vara_pkg::FRAC_Q30));
      degen <= degen_q;
    end
  end

endmodule

### src/vara_matrix.sv
// ----------------------------------------------------------------------------
// vara_matrix
// Builds c*I + K + (1 - c) w w^T in Q2.14 and selects identity for the
// degenerate cases.
// ----------------------------------------------------------------------------
module vara_matrix (
  input  logic                            clk,
  input  logic                            en,
  input  vara_pkg::q30_t                  w [3],
  input  vara_pkg::q30_t                  v [3],
  input  vara_pkg::q30_t                  c,
  input  logic [30:0]                     length,
  input  logic [vara_pkg::CFG_WIDTH-1:0]  limit,
  input  logic                            degen,
  input  logic                            zero_v,
  output vara_pkg::q14_t                  r [9],
  output vara_pkg::status_t               status
);

  typedef struct packed {
    logic [2:0][31:0] v;
    logic [31:0]      c;
    logic             degen;
    logic             par;
  } carry_t;

  // symmetric w w^T: entry (i,j) to one of six products
  localparam int PIDX [9] = '{0, 1, 2, 1, 3, 4, 2, 4, 5};
  localparam int WI   [6] = '{0, 0, 0, 1, 1, 2};
  localparam int WJ   [6] = '{0, 1, 2, 1, 2, 2};

  carry_t              m1_q, m2_q, m3_q, m4_q;
  logic signed [63:0]  pw_q  [6];
  vara_pkg::q30_t      p_q   [6];
  logic signed [33:0]  omc_q;
  logic signed [65:0]  op_q  [6];
  vara_pkg::wide_t     acc_q [9];
  vara_pkg::wide_t     kv    [9];
  vara_pkg::q30_t      v3    [3];
  vara_pkg::wide_t     rnd   [9];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        pw_q[i] <= w[WI[i]] * w[WJ[i]];
      end
      for (int i = 0; i < 3; i++) begin
        m1_q.v[i] <= v[i];
      end
      m1_q.c     <= c;
      m1_q.degen <= degen;
      m1_q.par   <= (length <= limit) || zero_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        p_q[i] <= vara_pkg::q30_t'(vara_pkg::round_shift(vara_pkg::wide_t'(pw_q[i]),
                                                         vara_pkg::FRAC_Q30));
      end
      omc_q <= 34'sh40000000 - 34'(signed'(m1_q.c));
      m2_q  <= m1_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        op_q[i] <= omc_q * p_q[i];
      end
      m3_q <= m2_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v3[i] = signed'(m3_q.v[i]);
    end
    kv[0] = '0;
    kv[1] = -vara_pkg::wide_t'(v3[2]);
    kv[2] = vara_pkg::wide_t'(v3[1]);
    kv[3] = vara_pkg::wide_t'(v3[2]);
    kv[4] = '0;
    kv[5] = -vara_pkg::wide_t'(v3[0]);
    kv[6] = -vara_pkg::wide_t'(v3[1]);
    kv[7] = vara_pkg::wide_t'(v3[0]);
    kv[8] = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 9; e++) begin
        acc_q[e] <= (kv[e] <<< vara_pkg::FRAC_Q30) + vara_pkg::wide_t'(op_q[PIDX[e]])
                    + ((e % 4 == 0) ? (vara_pkg::wide_t'(signed'(m3_q.c)) <<< vara_pkg::FRAC_Q30)
                                    : vara_pkg::wide_t'(0));
      end
      m4_q <= m3_q;
    end
  end

  always_comb begin
    for (int e = 0; e < 9; e++) begin
      rnd[e] = vara_pkg::round_shift(acc_q[e], vara_pkg::OUT_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 9; e++) begin
        if (m4_q.degen || m4_q.par) begin
          r[e] <= (e % 4 == 0) ? vara_pkg::ONE_Q14 : vara_pkg::q14_t'(0);
        end else if (rnd[e] > vara_pkg::wide_t'(vara_pkg::MAX_Q14)) begin
          r[e] <= vara_pkg::MAX_Q14;
        end else if (rnd[e] < vara_pkg::wide_t'(vara_pkg::MIN_Q14)) begin
          r[e] <= vara_pkg::MIN_Q14;
        end else begin
          r[e] <= vara_pkg::q14_t'(rnd[e]);
        end
      end
      priority if (m4_q.degen) begin
        status <= vara_pkg::ST_ZERO;
      end else if (m4_q.par) begin
        status <= vara_pkg::ST_PARALLEL;
      end else begin
        status <= vara_pkg::ST_ROTATION;
      end
    end
  end

endmodule

### src/vector_align_rotation_matrix.sv
// ----------------------------------------------------------------------------
// vector_align_rotation_matrix
// Rotation matrix that turns a source direction into a destination direction.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with src_x..dst_z in signed Q8.8. A
// transaction is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with r00..r22 in signed Q2.14 and
// align_status (0 rotation, 1 parallel or antiparallel, 2 zero-length input).
// The pipeline is two unit-vector stages (squared length, 5 normalising steps,
// 31-stage square root, 31-stage dividers), then cross and dot product, then
// matrix assembly. Throughput is one transaction per cycle while out_stall
// does not hold the pipeline; every stage is a register stage. When the
// receiver stalls with a result waiting, the whole pipeline holds and in_stall
// is raised in the same cycle; nothing is dropped or repeated. The user must
// write parallel_limit (cfg_write_en / cfg_write_data) only while the pipeline
// is empty; the block does not enforce it. Synchronous reset clears all valid
// bits and loads parallel_limit with 1074; no clearing pass is needed.
// ----------------------------------------------------------------------------
module vector_align_rotation_matrix (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_en,
  input  logic [vara_pkg::CFG_WIDTH-1:0]       cfg_write_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [vara_pkg::VEC_WIDTH-1:0] src_x,
  input  logic signed [vara_pkg::VEC_WIDTH-1:0] src_y,
  input  logic signed [vara_pkg::VEC_WIDTH-1:0] src_z,
  input  logic signed [vara_pkg::VEC_WIDTH-1:0] dst_x,
  input  logic signed [vara_pkg::VEC_WIDTH-1:0] dst_y,
  input  logic signed [vara_pkg::VEC_WIDTH-1:0] dst_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [15:0]                   r00,
  output logic signed [15:0]                   r01,
  output logic signed [15:0]                   r02,
  output logic signed [15:0]                   r10,
  output logic signed [15:0]                   r11,
  output logic signed [15:0]                   r12,
  output logic signed [15:0]                   r20,
  output logic signed [15:0]                   r21,
  output logic signed [15:0]                   r22,
  output logic [1:0]                           align_status
);

  typedef struct packed {
    logic [2:0][31:0] v;
    logic [31:0]      c;
    logic             degen;
  } vsb_t;

  logic                               en;
  logic [vara_pkg::CFG_WIDTH-1:0]     parallel_limit;
  logic [vara_pkg::PIPE_LAT-1:0]      vld;
  vara_pkg::q30_t                     src_v [3];
  vara_pkg::q30_t                     dst_v [3];
  vara_pkg::q30_t                     ua [3];
  vara_pkg::q30_t                     ub [3];
  logic                               za;
  logic                               zb;
  vara_pkg::q30_t                     cv [3];
  vara_pkg::q30_t                     cc;
  logic                               cdegen;
  vsb_t                               vsb_q [vara_pkg::UNIT_LAT];
  vara_pkg::q30_t                     wv [3];
  logic [30:0]                        s_len;
  logic                               zero_v;
  vara_pkg::q30_t                     dv [3];
  vara_pkg::q14_t                     r [9];
  vara_pkg::status_t                  status;

  assign in_stall = out_valid && out_stall;
  assign en       = !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      parallel_limit <= vara_pkg::LIMIT_RESET;
    end else if (cfg_write_en) begin
      parallel_limit <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[vara_pkg::PIPE_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[vara_pkg::PIPE_LAT-1];

  assign src_v[0] = 32'(src_x);
  assign src_v[1] = 32'(src_y);
  assign src_v[2] = 32'(src_z);
  assign dst_v[0] = 32'(dst_x);
  assign dst_v[1] = 32'(dst_y);
  assign dst_v[2] = 32'(dst_z);

  vara_unit3 u_unit_src (
    .clk      (clk),
    .en       (en),
    .comp     (src_v),
    .unit_vec (ua),
    .length   (),
    .zero     (za)
  );

  vara_unit3 u_unit_dst (
    .clk      (clk),
    .en       (en),
    .comp     (dst_v),
    .unit_vec (ub),
    .length   (),
    .zero     (zb)
  );

  vara_cross u_cross (
    .clk      (clk),
    .en       (en),
    .a        (ua),
    .b        (ub),
    .degen_in (za || zb),
    .v        (cv),
    .c        (cc),
    .degen    (cdegen)
  );

  vara_unit3 u_unit_axis (
    .clk      (clk),
    .en       (en),
    .comp     (cv),
    .unit_vec (wv),
    .length   (s_len),
    .zero     (zero_v)
  );

  // v, c and the zero-input flag ride alongside the axis normalisation
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        vsb_q[0].v[i] <= cv[i];
      end
      vsb_q[0].c     <= cc;
      vsb_q[0].degen <= cdegen;
      for (int j = 1; j < vara_pkg::UNIT_LAT; j++) begin
        vsb_q[j] <= vsb_q[j-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv[i] = signed'(vsb_q[vara_pkg::UNIT_LAT-1].v[i]);
    end
  end

  vara_matrix u_matrix (
    .clk    (clk),
    .en     (en),
    .w      (wv),
    .v      (dv),
    .c      (signed'(vsb_q[vara_pkg::UNIT_LAT-1].c)),
    .length (s_len),
    .limit  (parallel_limit),
    .degen  (vsb_q[vara_pkg::UNIT_LAT-1].degen),
    .zero_v (zero_v),
    .r      (r),
    .status (status)
  );

  assign r00 = r[0];
  assign r01 = r[1];
  assign r02 = r[2];
  assign r10 = r[3];
  assign r11 = r[4];
  assign r12 = r[5];
  assign r20 = r[6];
  assign r21 = r[7];
  assign r22 = r[8];
  assign align_status = status;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the vector alignment rotation matrix block. Vector pairs go through
// a queue-fed driver, and results are checked by a monitor against a
// fixed-point predictor. The run steps through several parallel limits and
// idling patterns, with one long receiver hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module tb_top;

  typedef longint vec3_t [3];
  typedef struct {
    logic signed [15:0] comp [6];
  } pair_t;
  typedef struct {
    logic signed [15:0]  entry [9];
    vara_pkg::status_t   status;
  } matrix_t;

  localparam longint ONE_Q30_L = 64'sd1 << 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [vara_pkg::CFG_WIDTH-1:0] cfg_write_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] src_x = '0, src_y = '0, src_z = '0;
  logic signed [15:0] dst_x = '0, dst_y = '0, dst_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic [1:0] align_status;

  pair_t   pending_pairs [$];
  matrix_t expected_matrices [$];
  pair_t   cur_pair;
  logic [vara_pkg::CFG_WIDTH-1:0] limit_copy = vara_pkg::LIMIT_RESET;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int mismatches = 0;
  int hold_left = 0;
  logic hold_go = 1'b0;

  vector_align_rotation_matrix dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .src_x(src_x), .src_y(src_y), .src_z(src_z),
    .dst_x(dst_x), .dst_y(dst_y), .dst_z(dst_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
    .r20(r20), .r21(r21), .r22(r22), .align_status(align_status)
  );

  always #10 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint round_shift_l(longint v, int sh);
    longint unsigned m;
    m = (magnitude(v) + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint div_round(longint num, longint unsigned den);
    longint unsigned m;
    m = (magnitude(num) + den / 2) / den;
    return num < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic bit to_unit(input vec3_t vin, output vec3_t vout);
    longint unsigned n2, n;
    vec3_t a;
    n2 = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = vin[i];
      n2 += magnitude(a[i]) * magnitude(a[i]);
      vout[i] = 0;
    end
    if (n2 == 0) return 1'b0;
    while (n2 < (64'd1 << 60)) begin
      for (int i = 0; i < 3; i++) a[i] *= 2;
      n2 *= 4;
    end
    n = int_sqrt(n2);
    for (int i = 0; i < 3; i++) vout[i] = div_round(a[i] * ONE_Q30_L, n);
    return 1'b1;
  endfunction

  function automatic matrix_t identity_of(vara_pkg::status_t st);
    matrix_t m;
    for (int i = 0; i < 9; i++) m.entry[i] = (i % 4 == 0) ? vara_pkg::ONE_Q14 : 16'sd0;
    m.status = st;
    return m;
  endfunction

  function automatic matrix_t rotation_of(pair_t p, logic [vara_pkg::CFG_WIDTH-1:0] limit);
    vec3_t sv, dv, a, b, v, w;
    longint k [9];
    longint c, omc, prod, acc, r;
    longint unsigned s2, s;
    matrix_t m;
    for (int i = 0; i < 3; i++) begin
      sv[i] = p.comp[i];
      dv[i] = p.comp[3 + i];
    end
    if (!to_unit(sv, a) || !to_unit(dv, b)) return identity_of(vara_pkg::ST_ZERO);
    v[0] = round_shift_l(a[1] * b[2] - a[2] * b[1], vara_pkg::FRAC_Q30);
    v[1] = round_shift_l(a[2] * b[0] - a[0] * b[2], vara_pkg::FRAC_Q30);
    v[2] = round_shift_l(a[0] * b[1] - a[1] * b[0], vara_pkg::FRAC_Q30);
    c = round_shift_l(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], vara_pkg::FRAC_Q30);
    s2 = 0;
    for (int i = 0; i < 3; i++) s2 += magnitude(v[i]) * magnitude(v[i]);
    s = int_sqrt(s2);
    if (s <= longint'(limit) || !to_unit(v, w)) return identity_of(vara_pkg::ST_PARALLEL);
    k = '{0, -v[2], v[1], v[2], 0, -v[0], -v[1], v[0], 0};
    omc = ONE_Q30_L - c;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod = round_shift_l(w[i] * w[j], vara_pkg::FRAC_Q30);
        acc = k[i * 3 + j] * ONE_Q30_L + omc * prod;
        if (i == j) acc += c * ONE_Q30_L;
        r = round_shift_l(acc, vara_pkg::OUT_SHIFT);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        m.entry[i * 3 + j] = 16'(r);
      end
    end
    m.status = vara_pkg::ST_ROTATION;
    return m;
  endfunction

  // driver: a new transaction is offered only once the previous one is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_matrices.insert(expected_matrices.size(), rotation_of(cur_pair, limit_copy));
      if (!in_valid || !in_stall) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          cur_pair = pending_pairs.pop_front();
          in_valid <= 1'b1;
          src_x <= cur_pair.comp[0];
          src_y <= cur_pair.comp[1];
          src_z <= cur_pair.comp[2];
          dst_x <= cur_pair.comp[3];
          dst_y <= cur_pair.comp[4];
          dst_z <= cur_pair.comp[5];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_go) begin
      hold_left <= 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    matrix_t exp_m;
    logic signed [15:0] got [9];
    if (!rst && out_valid && !out_stall) begin
      got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
      if (expected_matrices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction at output");
      end else begin
        exp_m = expected_matrices.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got[i] !== exp_m.entry[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("entry %0d: expected %0d got %0d", i, exp_m.entry[i], got[i]);
          end
        end
        if (align_status !== exp_m.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("status: expected %0d got %0d", exp_m.status, align_status);
        end
      end
    end
  end

  function automatic logic signed [15:0] clip16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  function automatic pair_t make_pair(int kind);
    pair_t p;
    int base [3];
    int mult;
    int zsel;
    case (kind)
      0, 1: for (int i = 0; i < 6; i++) p.comp[i] = 16'($urandom);
      2: for (int i = 0; i < 6; i++) p.comp[i] = clip16($urandom_range(0, 20) - 10);
      3, 4, 5: begin
        // near parallel or antiparallel pairs
        mult = $urandom_range(0, 3);
        mult = (mult == 0) ? 1 : (mult == 1) ? 2 : (mult == 2) ? -1 : -3;
        for (int i = 0; i < 3; i++) begin
          base[i] = $urandom_range(0, 4000) - 2000;
          p.comp[i] = clip16(base[i]);
          p.comp[3 + i] = clip16(base[i] * mult + $urandom_range(0, 4) - 2);
        end
      end
      6: begin
        for (int i = 0; i < 6; i++) p.comp[i] = 16'($urandom);
        zsel = $urandom_range(1) ? 0 : 3;
        for (int i = 0; i < 3; i++) p.comp[zsel + i] = '0;
      end
      default: begin
        for (int i = 0; i < 6; i++)
          p.comp[i] = $urandom_range(1) ? -16'sd32768 : 16'sd32767;
      end
    endcase
    return p;
  endfunction

  task automatic add_pair(int a0, int a1, int a2, int b0, int b1, int b2);
    pair_t p;
    p.comp = '{16'(a0), 16'(a1), 16'(a2), 16'(b0), 16'(b1), 16'(b2)};
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  task automatic wait_idle();
    while (pending_pairs.size() != 0 || in_valid || expected_matrices.size() != 0)
      @(posedge clk);
    repeat (vara_pkg::PIPE_LAT + 10) @(posedge clk);
  endtask

  initial begin
    logic [vara_pkg::CFG_WIDTH-1:0] limits [6];
    limits = '{vara_pkg::LIMIT_RESET, 31'd0, 31'h4000_0000, 31'h7FFF_FFFF,
               31'($urandom_range(0, 1 << 20)), vara_pkg::LIMIT_RESET};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero-length, extremes, parallel, antiparallel and orthogonal cases
    add_pair(0, 0, 0, 256, 0, 0);
    add_pair(256, 0, 0, 0, 0, 0);
    add_pair(0, 0, 0, 0, 0, 0);
    add_pair(256, 0, 0, 256, 0, 0);
    add_pair(256, 0, 0, -256, 0, 0);
    add_pair(256, 0, 0, 0, 256, 0);
    add_pair(0, 256, 0, 0, 0, 256);
    add_pair(0, 0, 256, 256, 0, 0);
    add_pair(-32768, -32768, -32768, 32767, 32767, 32767);
    add_pair(32767, 32767, 32767, 32767, 32767, 32767);
    add_pair(-32768, 0, 0, 0, -32768, 0);
    add_pair(1, 0, 0, 0, 1, 0);
    add_pair(1, 1, 1, -1, -1, -1);
    add_pair(-1, -1, -1, -1, -1, -1);
    add_pair(32767, -32768, 1, -1, 32767, -32768);
    add_pair(100, 200, 300, 101, 200, 300);
    add_pair(1000, 0, 0, 1000, 1, 0);
    add_pair(256, 256, 0, 0, 256, 256);
    add_pair(-21846, 21845, 0, 21845, 21845, -1);
    add_pair(3, -5, 7, 7, 5, -3);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) begin
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= limits[ph];
        @(posedge clk);
        cfg_write_en <= 1'b0;
        limit_copy = limits[ph];
      end
      case (ph % 3)
        0: begin tx_idle_pct = 7;  rx_stall_pct = 85; end
        1: begin tx_idle_pct = 85; rx_stall_pct = 7;  end
        default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
      endcase
      for (int n = 0; n < 267; n++)
        pending_pairs.insert(pending_pairs.size(), make_pair($urandom_range(0, 7)));
      if (ph == 2) begin
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      wait_idle();
    end

    if (mismatches == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #(20 * 600000);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
